// ===== rtl/tlr_pkg.sv =====
// shared types and constants for the tile line rasterizer
package tlr_pkg;

    localparam int MAP_DIM_DEF    = 64;
    localparam int PIXEL_BITS_DEF = 16;

    localparam int TILE_W      = 6;
    localparam int VALUE_W     = 12;
    localparam int SHIFT_W     = 3;
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = 6;
    localparam int OUT_W       = 32;

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = APB_ADDR_W - 2;

    localparam logic [SHIFT_W-1:0]   SHIFT_RESET    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TILE_SHIFT = '0;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SETUP,
        ST_WALK
    } state_t;

    typedef struct packed
    {
        logic accept;
        logic setup;
        logic step;
    } dp_cmd_t;

    typedef struct packed
    {
        logic painting;
        logic fin;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/tlr_ctrl.sv =====
// sequencer for frame accept, line setup and point walk
module tlr_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  tlr_pkg::dp_status_t status,
    output tlr_pkg::dp_cmd_t    cmd
);

    tlr_pkg::state_t state_reg;
    tlr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            tlr_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = tlr_pkg::ST_SETUP;
                end
            end
            tlr_pkg::ST_SETUP:
            begin
                cmd.setup = 1'b1;
                if (status.painting)
                begin
                    state_next = tlr_pkg::ST_WALK;
                end
                else
                begin
                    state_next = tlr_pkg::ST_IDLE;
                end
            end
            tlr_pkg::ST_WALK:
            begin
                if (status.out_free)
                begin
                    cmd.step = 1'b1;
                    if (status.fin)
                    begin
                        state_next = tlr_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = tlr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/tlr_datapath.sv =====
// tile conversion, stroke state, line stepper and output register
module tlr_datapath #(
    parameter int MAP_DIM    = tlr_pkg::MAP_DIM_DEF,
    parameter int PIXEL_BITS = tlr_pkg::PIXEL_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tlr_pkg::SHIFT_W-1:0]   tile_shift,
    input  logic                          button_down,
    input  logic                          click_blocked,
    input  logic [PIXEL_BITS-1:0]         pos_x,
    input  logic [PIXEL_BITS-1:0]         pos_y,
    input  logic                          layer,
    input  logic [tlr_pkg::VALUE_W-1:0]   tile_index,
    input  tlr_pkg::dp_cmd_t              cmd,
    output tlr_pkg::dp_status_t           status,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [tlr_pkg::TILE_W-1:0]    tile_x,
    output logic [tlr_pkg::TILE_W-1:0]    tile_y,
    output logic                          target_layer,
    output logic [tlr_pkg::VALUE_W-1:0]   tile_value,
    output logic                          last
);

    localparam int CW    = (MAP_DIM > 1) ? $clog2(MAP_DIM) : 1;
    localparam int ERR_W = CW + 2;
    localparam int E2_W  = CW + 3;
    localparam logic [PIXEL_BITS-1:0] PIX_MAX = PIXEL_BITS'(MAP_DIM - 1);
    localparam logic [CW-1:0]         TILE_MAX = CW'(MAP_DIM - 1);

    logic [PIXEL_BITS-1:0] shx;
    logic [PIXEL_BITS-1:0] shy;
    logic [CW-1:0]         cx;
    logic [CW-1:0]         cy;

    logic [CW-1:0]               cur_x_reg, cur_y_reg;
    logic                        painting_reg;
    logic                        layer_reg;
    logic [tlr_pkg::VALUE_W-1:0] value_reg;
    logic                        held_reg, held_next;
    logic [CW-1:0]               prev_x_reg, prev_y_reg;
    logic [CW-1:0]               x_reg, y_reg;
    logic [CW-1:0]               dx_reg, dy_reg;
    logic                        sx_reg, sy_reg;
    logic signed [ERR_W-1:0]     err_reg;
    logic [tlr_pkg::CNT_W-1:0]   cnt_reg;

    logic [CW-1:0]           start_x, start_y;
    logic [CW-1:0]           dx_init, dy_init;
    logic signed [E2_W-1:0]  e2;
    logic signed [E2_W-1:0]  dx_s, dy_s;
    logic                    step_x, step_y;
    logic signed [E2_W-1:0]  err_sum;
    logic                    fin;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [tlr_pkg::TILE_W-1:0]  tile_x_reg, tile_y_reg;
    logic                        layer_out_reg;
    logic [tlr_pkg::VALUE_W-1:0] value_out_reg;
    logic                        last_reg;

    // pixel to tile with saturation at the map edge
    always_comb
    begin
        shx = pos_x >> tile_shift;
        shy = pos_y >> tile_shift;
        cx  = (shx > PIX_MAX) ? TILE_MAX : shx[CW-1:0];
        cy  = (shy > PIX_MAX) ? TILE_MAX : shy[CW-1:0];
    end

    // line setup: a fresh stroke walks from the current tile to itself
    always_comb
    begin
        start_x = held_reg ? prev_x_reg : cur_x_reg;
        start_y = held_reg ? prev_y_reg : cur_y_reg;
        dx_init = (cur_x_reg > start_x) ? (cur_x_reg - start_x) : (start_x - cur_x_reg);
        dy_init = (cur_y_reg > start_y) ? (cur_y_reg - start_y) : (start_y - cur_y_reg);
        held_next = painting_reg;
    end

    // one bresenham step
    always_comb
    begin
        dx_s    = $signed(E2_W'(dx_reg));
        dy_s    = $signed(E2_W'(dy_reg));
        e2      = $signed({err_reg, 1'b0});
        step_x  = e2 > -dy_s;
        step_y  = e2 < dx_s;
        err_sum = E2_W'(err_reg) - (step_x ? dy_s : '0) + (step_y ? dx_s : '0);
        fin     = ((x_reg == cur_x_reg) && (y_reg == cur_y_reg))
                  || (cnt_reg == tlr_pkg::CNT_W'(tlr_pkg::MAX_RESULTS - 1));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cur_x_reg    <= cx;
            cur_y_reg    <= cy;
            painting_reg <= button_down & ~click_blocked;
            layer_reg    <= layer;
            value_reg    <= tile_index;
        end
        if (cmd.setup)
        begin
            x_reg   <= start_x;
            y_reg   <= start_y;
            dx_reg  <= dx_init;
            dy_reg  <= dy_init;
            sx_reg  <= start_x < cur_x_reg;
            sy_reg  <= start_y < cur_y_reg;
            err_reg <= $signed(ERR_W'(dx_init)) - $signed(ERR_W'(dy_init));
            cnt_reg <= '0;
        end
        else if (cmd.step)
        begin
            if (step_x)
            begin
                x_reg <= sx_reg ? x_reg + 1'b1 : x_reg - 1'b1;
            end
            if (step_y)
            begin
                y_reg <= sy_reg ? y_reg + 1'b1 : y_reg - 1'b1;
            end
            err_reg <= err_sum[ERR_W-1:0];
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.step)
        begin
            tile_x_reg    <= tlr_pkg::TILE_W'(x_reg);
            tile_y_reg    <= tlr_pkg::TILE_W'(y_reg);
            layer_out_reg <= layer_reg;
            value_out_reg <= value_reg;
            last_reg      <= fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg     <= 1'b0;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.setup)
            begin
                held_reg   <= held_next;
                prev_x_reg <= cur_x_reg;
                prev_y_reg <= cur_y_reg;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb
    begin
        if (cmd.step)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign status.painting = painting_reg;
    assign status.fin      = fin;
    assign status.out_free = ~m_tvalid_reg | m_tready;

    assign m_tvalid     = m_tvalid_reg;
    assign tile_x       = tile_x_reg;
    assign tile_y       = tile_y_reg;
    assign target_layer = layer_out_reg;
    assign tile_value   = value_out_reg;
    assign last         = last_reg;

endmodule

// ===== rtl/tile_line_rasterizer.sv =====
// top level of the tile line rasterizer: config register, controller and datapath
//
// one input beat is one frame tick: paint button, block flag, pointer pixel
// position, layer and tile index. the pixel position is shifted right by
// tile_shift (apb register at address 0, reset 4) and saturated to the map
// edge. a painting frame emits tile writes on the output stream: a single
// write at the start of a stroke, otherwise one write per point of the line
// from the previous tick's tile to this one, both ends included, with tlast
// on the final write. a frame that does not paint emits nothing.
// an input beat is taken only while the block is idle. after the accept the
// setup state follows, then one output beat per cycle as long as the output
// register is free, through the single line stepper. a stall on the output
// side holds the stepper and the input stays blocked until the last write is
// loaded; the next frame is taken while that last write still waits. reset
// clears the stroke state and the previous tile to zero and empties the output
// register.
module tile_line_rasterizer #(
    parameter int MAP_DIM    = tlr_pkg::MAP_DIM_DEF,
    parameter int PIXEL_BITS = tlr_pkg::PIXEL_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tlr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tlr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tlr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // button_down, click_blocked, pos_x, pos_y, layer, tile_index, zero fill
    input  logic [((2*PIXEL_BITS+3+tlr_pkg::VALUE_W+7)/8)*8-1:0] s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tile_x, tile_y, target_layer, tile_value, zero fill
    output logic [tlr_pkg::OUT_W-1:0]         m_tdata,
    output logic                              m_tlast
);

    localparam int PX_LO     = 2;
    localparam int PY_LO     = PX_LO + PIXEL_BITS;
    localparam int LAYER_BIT = PY_LO + PIXEL_BITS;
    localparam int VAL_LO    = LAYER_BIT + 1;
    localparam int OUT_USED  = 2 * tlr_pkg::TILE_W + 1 + tlr_pkg::VALUE_W;

    logic [tlr_pkg::SHIFT_W-1:0]   shift_reg;
    logic [tlr_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          cfg_write;

    tlr_pkg::dp_cmd_t    cmd;
    tlr_pkg::dp_status_t status;

    logic [tlr_pkg::TILE_W-1:0]  tile_x;
    logic [tlr_pkg::TILE_W-1:0]  tile_y;
    logic                        target_layer;
    logic [tlr_pkg::VALUE_W-1:0] tile_value;

    assign reg_idx   = paddr[tlr_pkg::APB_ADDR_W-1:2];
    assign cfg_write = psel & penable & pwrite & pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= tlr_pkg::SHIFT_RESET;
        end
        else if (cfg_write && (reg_idx == tlr_pkg::REG_TILE_SHIFT))
        begin
            shift_reg <= pwdata[tlr_pkg::SHIFT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == tlr_pkg::REG_TILE_SHIFT)
        begin
            prdata = tlr_pkg::APB_DATA_W'(shift_reg);
        end
    end

    tlr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tlr_datapath #(
        .MAP_DIM    (MAP_DIM),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .tile_shift    (shift_reg),
        .button_down   (s_tdata[0]),
        .click_blocked (s_tdata[1]),
        .pos_x         (s_tdata[PY_LO-1:PX_LO]),
        .pos_y         (s_tdata[LAYER_BIT-1:PY_LO]),
        .layer         (s_tdata[LAYER_BIT]),
        .tile_index    (s_tdata[VAL_LO+tlr_pkg::VALUE_W-1:VAL_LO]),
        .cmd           (cmd),
        .status        (status),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .tile_x        (tile_x),
        .tile_y        (tile_y),
        .target_layer  (target_layer),
        .tile_value    (tile_value),
        .last          (m_tlast)
    );

    assign m_tdata = {{(tlr_pkg::OUT_W-OUT_USED){1'b0}}, tile_value, target_layer,
                      tile_y, tile_x};

    // a taken frame blocks the input for at least the setup cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted during line setup");

    // every emitted write lies inside the map
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (32'(tile_x) < MAP_DIM) && (32'(tile_y) < MAP_DIM))
        else $error("tile write outside the map");

    // no output beat is produced while a new frame is being set up
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("output beat appeared during setup");

endmodule

// ===== sim/tlr_stroke_checker.sv =====
// stroke checker: predicts the tile writes of each frame beat and compares the output stream
`timescale 1ns / 100ps

module tlr_stroke_checker
    import tlr_pkg::*;
#(
    parameter int MAP_DIM    = MAP_DIM_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    parameter int IN_W       = ((2*PIXEL_BITS+3+VALUE_W+7)/8)*8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    input  logic                  pready,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_W-1:0]      m_tdata,
    input  logic                  m_tlast,
    output int                    errors,
    output int                    pending,
    output int                    writes_checked
);

    typedef struct packed
    {
        logic [TILE_W-1:0]  x;
        logic [TILE_W-1:0]  y;
        logic               layer;
        logic [VALUE_W-1:0] value;
        logic               last;
    } tile_write_t;

    tile_write_t        expected_writes [$];
    logic [SHIFT_W-1:0] tile_shift;
    logic               stroke_active;
    int                 last_tile_x;
    int                 last_tile_y;

    function automatic int pixel_tile(input logic [PIXEL_BITS-1:0] pix);
        int t;
        t = int'(pix) >> tile_shift;
        if (t > MAP_DIM - 1)
            t = MAP_DIM - 1;
        return t;
    endfunction

    task automatic rasterize_frame(input logic [IN_W-1:0] beat);
        logic               painting;
        logic               lay;
        logic [VALUE_W-1:0] val;
        logic               fin;
        int                 cx, cy, x0, y0, dx, dy, sx, sy, err, e2, n;
        tile_write_t        w;
        painting = beat[0] & ~beat[1];
        cx  = pixel_tile(beat[2 +: PIXEL_BITS]);
        cy  = pixel_tile(beat[2+PIXEL_BITS +: PIXEL_BITS]);
        lay = beat[2+2*PIXEL_BITS];
        val = beat[3+2*PIXEL_BITS +: VALUE_W];
        if (painting)
        begin
            if (!stroke_active)
            begin
                w = '{x: TILE_W'(cx), y: TILE_W'(cy), layer: lay, value: val, last: 1'b1};
                expected_writes = {expected_writes, w};
            end
            else
            begin
                x0  = last_tile_x;
                y0  = last_tile_y;
                dx  = (cx > x0) ? cx - x0 : x0 - cx;
                dy  = (cy > y0) ? cy - y0 : y0 - cy;
                sx  = (x0 < cx) ? 1 : -1;
                sy  = (y0 < cy) ? 1 : -1;
                err = dx - dy;
                n   = 0;
                while (n < MAX_RESULTS)
                begin
                    fin = ((x0 == cx) && (y0 == cy)) || (n == MAX_RESULTS - 1);
                    w = '{x: TILE_W'(x0), y: TILE_W'(y0), layer: lay, value: val, last: fin};
                    expected_writes = {expected_writes, w};
                    n++;
                    if (fin)
                        break;
                    e2 = 2 * err;
                    if (e2 > -dy)
                    begin
                        err -= dy;
                        x0  += sx;
                    end
                    if (e2 < dx)
                    begin
                        err += dx;
                        y0  += sy;
                    end
                end
            end
            stroke_active = 1'b1;
        end
        else
            stroke_active = 1'b0;
        last_tile_x = cx;
        last_tile_y = cy;
    endtask

    task automatic check_write();
        tile_write_t exp_w;
        tile_write_t got_w;
        got_w = '{x: m_tdata[0 +: TILE_W], y: m_tdata[TILE_W +: TILE_W],
                  layer: m_tdata[2*TILE_W], value: m_tdata[2*TILE_W+1 +: VALUE_W],
                  last: m_tlast};
        if (expected_writes.size() == 0)
        begin
            errors++;
            if (errors <= 20)
                $display("%0t: unexpected tile write x=%0d y=%0d layer=%0d value=%0d last=%0d",
                         $time, got_w.x, got_w.y, got_w.layer, got_w.value, got_w.last);
        end
        else
        begin
            exp_w = expected_writes[0];
            expected_writes.delete(0);
            writes_checked++;
            if (got_w !== exp_w)
            begin
                errors++;
                // fields x/y/layer/value/last
                if (errors <= 20)
                    $display("%0t: write expected %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                             $time, exp_w.x, exp_w.y, exp_w.layer, exp_w.value, exp_w.last,
                             got_w.x, got_w.y, got_w.layer, got_w.value, got_w.last);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_shift     = SHIFT_RESET;
            stroke_active  = 1'b0;
            last_tile_x    = 0;
            last_tile_y    = 0;
            errors         = 0;
            writes_checked = 0;
            expected_writes.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_write();
            if (s_tvalid && s_tready)
                rasterize_frame(s_tdata);
            if (psel && penable && pready && (paddr[APB_ADDR_W-1:2] == REG_TILE_SHIFT))
            begin
                if (pwrite)
                    tile_shift = pwdata[SHIFT_W-1:0];
                else if (prdata !== APB_DATA_W'(tile_shift))
                begin
                    errors++;
                    if (errors <= 20)
                        $display("%0t: tile_shift read expected %0d, got %0d",
                                 $time, tile_shift, prdata);
                end
            end
        end
        pending = expected_writes.size();
    end

endmodule

// ===== sim/tile_line_rasterizer_test.sv =====
// testbench top for the tile line rasterizer: clock, reset, frame stimulus and verdict
`timescale 1ns / 100ps

module tile_line_rasterizer_test;
    import tlr_pkg::*;

    localparam int PIXEL_BITS    = PIXEL_BITS_DEF;
    localparam int IN_W          = ((2*PIXEL_BITS+3+VALUE_W+7)/8)*8;
    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_FRAMES = 192;
    localparam int PHASES        = 8;
    localparam logic [REG_IDX_W-1:0]       REG_SPARE = 1'b1;
    localparam logic [PHASES*SHIFT_W-1:0] SHIFT_SEQ =
        {3'd4, 3'd3, 3'd6, 3'd2, 3'd5, 3'd1, 3'd7, 3'd0};

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;
    logic                  m_tlast;

    int errors;
    int pending;
    int writes_checked;
    int frames_sent;
    int idle_cycles;
    int cur_shift;
    bit quiet;

    tile_line_rasterizer DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    tlr_stroke_checker stroke_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .errors         (errors),
        .pending        (pending),
        .writes_checked (writes_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // output side back-pressure
    initial
    begin
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = $urandom_range(1, 16);
            repeat (n)
            begin
                @(negedge clk);
                m_tready <= 1'b1;
            end
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                n = $urandom_range(1, 12);
                repeat (n)
                begin
                    @(negedge clk);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    function automatic logic [IN_W-1:0] frame_beat(input int btn, input int blk,
                                                   input int x, input int y,
                                                   input int lay, input int idx);
        return IN_W'({VALUE_W'(idx), 1'(lay), PIXEL_BITS'(y), PIXEL_BITS'(x),
                      1'(blk), 1'(btn)});
    endfunction

    // mostly on-map positions for the current tile size, some anywhere
    function automatic int rand_pixel();
        int tile;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, (1 << PIXEL_BITS) - 1);
        tile = $urandom_range(0, 63);
        return (tile << cur_shift)
               | ($urandom_range(0, 255) & ((1 << cur_shift) - 1));
    endfunction

    task automatic send_frame(input logic [IN_W-1:0] beat);
        @(negedge clk);
        s_tdata  <= beat;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        frames_sent++;
    endtask

    task automatic paint(input int x, input int y, input int lay, input int idx);
        send_frame(frame_beat(1, 0, x, y, lay, idx));
    endtask

    task automatic hold_off(input int n);
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (n - 1)
            @(negedge clk);
    endtask

    task automatic maybe_gap();
        if (!quiet && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 12));
    endtask

    // let every predicted write come out, then allow time for a silent frame to finish
    task automatic drain();
        hold_off(1);
        while (pending != 0)
            @(negedge clk);
        repeat (8)
            @(negedge clk);
    endtask

    task automatic reg_access(input logic [REG_IDX_W-1:0] idx, input bit wr,
                              input logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_shift(input int s);
        drain();
        reg_access(REG_TILE_SHIFT, 1'b1, APB_DATA_W'(s));
        reg_access(REG_TILE_SHIFT, 1'b0, '0);
        cur_shift = s;
    endtask

    initial
    begin
        int target;
        int len;
        int kind;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        frames_sent = 0;
        cur_shift   = SHIFT_RESET;
        quiet       = 1'b0;
        repeat (4)
            @(negedge clk);
        rst_n <= 1'b1;

        reg_access(REG_TILE_SHIFT, 1'b0, '0);

        // field extremes, full-length diagonal, horizontal and vertical lines, stroke breaks
        paint(0, 0, 0, 'h000);
        paint('hFFFF, 'hFFFF, 1, 'hFFF);
        paint('hFFFF, 'hFFFF, 0, 'h5A5);
        paint(0, 'hFFFF, 1, 'h0F0);
        paint(0, 0, 0, 'hA5A);
        paint(645, 160, 1, 'h123);
        paint(48, 800, 0, 'h456);
        send_frame(frame_beat(1, 1, 800, 800, 1, 'h789));
        paint(112, 112, 0, 'hABC);
        send_frame(frame_beat(0, 1, 'h8000, 'h7FFF, 1, 'hDEF));
        send_frame(frame_beat(0, 0, 'h5555, 'hAAAA, 0, 'h321));
        paint(320, 320, 1, 'h654);
        paint(336, 960, 0, 'h987);
        paint(944, 976, 1, 'hCBA);

        // unused register index must leave tile_shift alone
        drain();
        reg_access(REG_SPARE, 1'b1, '0);
        reg_access(REG_TILE_SHIFT, 1'b0, '0);
        paint(480, 80, 0, 'h111);

        // tile size changes while a stroke is held
        set_shift(0);
        paint(5, 70, 1, 'h222);
        paint(63, 0, 0, 'h333);
        set_shift(7);
        paint('hFFFF, 0, 1, 'h444);
        paint(127, 128, 0, 'h555);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
                quiet = 1'b1;
            set_shift(int'(SHIFT_SEQ[p*SHIFT_W +: SHIFT_W]));
            target = frames_sent + RANDOM_FRAMES / PHASES;
            while (frames_sent < target)
            begin
                len = $urandom_range(1, 8);
                repeat (len)
                begin
                    maybe_gap();
                    paint(rand_pixel(), rand_pixel(), int'($urandom_range(0, 1)),
                          int'($urandom_range(0, (1 << VALUE_W) - 1)));
                end
                repeat ($urandom_range(0, 2))
                begin
                    maybe_gap();
                    kind = $urandom_range(0, 2);
                    send_frame(frame_beat(int'(kind == 2), int'(kind != 0),
                                          rand_pixel(), rand_pixel(),
                                          int'($urandom_range(0, 1)),
                                          int'($urandom_range(0, (1 << VALUE_W) - 1))));
                end
            end
        end

        drain();
        repeat (20)
            @(negedge clk);
        $display("summary: %0d frames driven, %0d tile writes checked",
                 frames_sent, writes_checked);
        $display("summary: tile sizes 1 to 128 px, saturated pointers, %s",
                 "strokes cut by release and block");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
